FILE: rtl/core/esw_pkg.sv
// ----------------------------------------------------------------------------
// esw_pkg
// Shared types, constants and slot helpers for the event/sample window
// correlator.
// ----------------------------------------------------------------------------
package esw_pkg;

    // Store geometry.
    localparam int STORE_DEPTH = 64;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int EXP_W       = 7;

    // Item codes.
    localparam logic CMD_EVENT  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Register indexes.
    localparam logic REG_MATCH_WINDOW   = 1'b0;
    localparam logic REG_RETENTION_SPAN = 1'b1;

    localparam logic [31:0] MATCH_WINDOW_RST   = 32'd1000;
    localparam logic [31:0] RETENTION_SPAN_RST = 32'd1000000000;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // One stored event, first field in the highest bits.
    typedef struct packed {
        logic [15:0] func;
        logic [31:0] thread;
        logic [31:0] proc;
        logic [31:0] span;
        logic [63:0] stamp;
    } esw_entry_t;

    // Verdict of the shared compare unit on one entry.
    typedef struct packed {
        logic        expire;
        logic        hit;
        logic        early;
        logic [31:0] delta;
    } esw_cmp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_EXP_END,
        ST_PUSH,
        ST_SC_RD,
        ST_SC_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE
    } esw_state_t;

    function automatic ptr_t slot_inc(input ptr_t p);
        return (p == ptr_t'(STORE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

    function automatic ptr_t slot_dec(input ptr_t p);
        return (p == '0) ? ptr_t'(STORE_DEPTH - 1) : p - ptr_t'(1);
    endfunction

endpackage

FILE: rtl/core/event_sample_window_correlator_core.sv
// ----------------------------------------------------------------------------
// event_sample_window_correlator_core
// Event store with retention expiry and windowed sample-to-event matching.
// ----------------------------------------------------------------------------
// An event item first expires old entries, then pushes itself; a sample also
// expires, then scans entries newest to oldest and, on a match, shifts the
// newer entries down over the removed one.
// One item is worked on at a time, each entry passing through the RAM's
// registered read and the shared compare unit; s_tready rises at the edge that
// loads the result register. Reset empties the store and loads defaults.
module event_sample_window_correlator_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // stamp[63:0], span_length[95:64], proc_tag[127:96], thread_tag[159:128],
    // func_id[175:160]
    input  logic [175:0] s_tdata,
    // cmd[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_func[15:0], hit_stamp[79:16], hit_span[111:80], hit_proc[143:112],
    // hit_thread[175:144], gap[207:176], dropped_oldest[208],
    // expired_count[215:209]
    output logic [215:0] m_tdata,
    // matched[0]
    output logic [0:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import esw_pkg::*;

    logic [31:0] match_window_reg;
    logic [31:0] retention_span_reg;
    logic        idle;
    logic        matched;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_window_reg   <= MATCH_WINDOW_RST;
            retention_span_reg <= RETENTION_SPAN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index[0])
                REG_MATCH_WINDOW:   match_window_reg   <= cfg_data;
                REG_RETENTION_SPAN: retention_span_reg <= cfg_data;
                default:            match_window_reg   <= match_window_reg;
            endcase
        end
    end

    esw_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (s_tvalid),
        .cmd            (s_tuser[0]),
        .item           (esw_entry_t'(s_tdata)),
        .match_window   (match_window_reg),
        .retention_span (retention_span_reg),
        .idle           (idle),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res_matched    (matched),
        .res_data       (m_tdata)
    );

    assign s_tready   = idle;
    assign m_tuser[0] = matched;

endmodule

FILE: rtl/core/esw_ram.sv
// ----------------------------------------------------------------------------
// esw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module esw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/esw_cmp.sv
// ----------------------------------------------------------------------------
// esw_cmp
// Shared time compare unit: judges one stored entry against the current item.
// ----------------------------------------------------------------------------
module esw_cmp (
    input  esw_pkg::esw_entry_t entry,
    input  esw_pkg::esw_entry_t item,
    input  logic [31:0]         match_window,
    input  logic [31:0]         retention_span,
    output esw_pkg::esw_cmp_t   verdict
);
    import esw_pkg::*;

    logic [63:0] start;
    logic [63:0] delta;
    logic [63:0] age;
    logic        tags_ok;

    // Span start clamps at zero; distance is zero inside the span.
    always_comb
    begin
        start = (entry.stamp > {32'd0, entry.span}) ? entry.stamp - {32'd0, entry.span}
                                                     : 64'd0;
        if (item.stamp < start)
        begin
            delta = start - item.stamp;
        end
        else if (item.stamp > entry.stamp)
        begin
            delta = item.stamp - entry.stamp;
        end
        else
        begin
            delta = 64'd0;
        end
        age = item.stamp - entry.stamp;
        tags_ok = (item.proc == 32'd0 || entry.proc == 32'd0 || item.proc == entry.proc) &&
                  (item.thread == 32'd0 || entry.thread == 32'd0 ||
                   item.thread == entry.thread);

        verdict.expire = (entry.stamp < item.stamp) && (age > {32'd0, retention_span});
        verdict.hit    = tags_ok && (delta <= {32'd0, match_window});
        verdict.early  = (item.stamp > entry.stamp) && (age > {32'd0, match_window});
        verdict.delta  = delta[31:0];
    end

endmodule

FILE: rtl/core/esw_ctrl.sv
// ----------------------------------------------------------------------------
// esw_ctrl
// Sequencer: expiry, push, newest-to-oldest scan and removal shift over the
// entry store, one entry per step through the shared compare unit.
// ----------------------------------------------------------------------------
module esw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    input  esw_pkg::esw_entry_t item,
    input  logic [31:0]         match_window,
    input  logic [31:0]         retention_span,
    output logic                idle,
    output logic                res_valid,
    input  logic                res_ready,
    output logic                res_matched,
    output logic [215:0]        res_data
);
    import esw_pkg::*;

    esw_state_t state_reg, state_next;

    ptr_t       oldest_reg, oldest_next;
    ptr_t       wr_ptr_reg, wr_ptr_next;
    cnt_t       count_reg, count_next;
    cnt_t       exp_reg, exp_next;
    ptr_t       idx_reg, idx_next;
    ptr_t       hit_idx_reg, hit_idx_next;
    cnt_t       left_reg, left_next;
    logic [32:0] best_d_reg, best_d_next;
    logic       found_reg, found_next;
    logic       drop_reg, drop_next;
    logic       cmd_reg;
    esw_entry_t item_reg;
    esw_entry_t hit_reg, hit_next;
    logic       valid_reg, valid_next;
    logic       matched_reg, matched_next;
    logic [215:0] data_reg, data_next;

    logic       ram_we;
    ptr_t       ram_waddr;
    esw_entry_t ram_wdata;
    logic       ram_re;
    ptr_t       ram_raddr;
    esw_entry_t ram_rdata;
    esw_cmp_t   verdict;
    logic       load_res;
    logic [EXP_W-1:0] exp_sat;

    esw_ram #(
        .WIDTH($bits(esw_entry_t)),
        .DEPTH(STORE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    esw_cmp u_cmp (
        .entry          (ram_rdata),
        .item           (item_reg),
        .match_window   (match_window),
        .retention_span (retention_span),
        .verdict        (verdict)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (start) state_next = ST_EXP_RD;
            ST_EXP_RD:  state_next = (count_reg == '0) ? ST_EXP_END : ST_EXP_CHK;
            ST_EXP_CHK: state_next = verdict.expire ? ST_EXP_RD : ST_EXP_END;
            ST_EXP_END:
            begin
                if (cmd_reg == CMD_EVENT)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_SC_RD;
                end
            end
            ST_PUSH:    state_next = ST_DONE;
            ST_SC_RD:   state_next = ST_SC_CHK;
            ST_SC_CHK:
            begin
                if (verdict.early || left_reg == cnt_t'(1))
                begin
                    if (found_reg || (verdict.hit && {1'b0, verdict.delta} < best_d_reg))
                    begin
                        state_next = ST_SH_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_SC_RD;
                end
            end
            ST_SH_RD:   state_next = (slot_inc(idx_reg) == wr_ptr_reg) ? ST_DONE : ST_SH_WR;
            ST_SH_WR:   state_next = ST_SH_RD;
            ST_DONE:    if (!valid_reg || res_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory controls and handshake outputs.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        load_res  = 1'b0;
        case (state_reg)
            ST_EXP_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = oldest_reg;
            end
            ST_PUSH:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_ptr_reg;
                ram_wdata = item_reg;
            end
            ST_SC_RD:
            begin
                ram_re = 1'b1;
            end
            ST_SH_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = slot_inc(idx_reg);
            end
            ST_SH_WR:
            begin
                ram_we = 1'b1;
            end
            ST_DONE:
            begin
                load_res = !valid_reg || res_ready;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign idle        = (state_reg == ST_IDLE);
    assign res_valid   = valid_reg;
    assign res_matched = matched_reg;
    assign res_data    = data_reg;

    // Expired count saturates at the field width.
    assign exp_sat = (32'(exp_reg) > 32'd127) ? 7'd127 : EXP_W'(exp_reg);

    // Datapath updates.
    always_comb
    begin
        oldest_next  = oldest_reg;
        wr_ptr_next  = wr_ptr_reg;
        count_next   = count_reg;
        exp_next     = exp_reg;
        idx_next     = idx_reg;
        left_next    = left_reg;
        best_d_next  = best_d_reg;
        found_next   = found_reg;
        drop_next    = drop_reg;
        hit_next     = hit_reg;
        valid_next   = valid_reg;
        matched_next = matched_reg;
        data_next    = data_reg;

        if (res_ready)
        begin
            valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                exp_next   = '0;
                drop_next  = 1'b0;
                found_next = 1'b0;
            end
            ST_EXP_CHK:
            begin
                if (verdict.expire)
                begin
                    oldest_next = slot_inc(oldest_reg);
                    count_next  = count_reg - cnt_t'(1);
                    exp_next    = exp_reg + cnt_t'(1);
                end
            end
            ST_EXP_END:
            begin
                idx_next    = slot_dec(wr_ptr_reg);
                left_next   = count_reg;
                best_d_next = {1'b0, match_window} + 33'd1;
            end
            ST_PUSH:
            begin
                if (count_reg == cnt_t'(STORE_DEPTH))
                begin
                    oldest_next = slot_inc(oldest_reg);
                    drop_next   = 1'b1;
                end
                else
                begin
                    count_next = count_reg + cnt_t'(1);
                end
                wr_ptr_next = slot_inc(wr_ptr_reg);
            end
            ST_SC_CHK:
            begin
                // Strict compare keeps the newer entry on a tie.
                if (verdict.hit && {1'b0, verdict.delta} < best_d_reg)
                begin
                    found_next  = 1'b1;
                    best_d_next = {1'b0, verdict.delta};
                    hit_next    = ram_rdata;
                end
                if (verdict.early || left_reg == cnt_t'(1))
                begin
                    if (verdict.hit && {1'b0, verdict.delta} < best_d_reg)
                    begin
                        idx_next = idx_reg;
                    end
                    else
                    begin
                        idx_next = hit_idx_reg;
                    end
                end
                else
                begin
                    idx_next  = slot_dec(idx_reg);
                    left_next = left_reg - cnt_t'(1);
                end
            end
            ST_SH_RD:
            begin
                if (slot_inc(idx_reg) == wr_ptr_reg)
                begin
                    wr_ptr_next = idx_reg;
                    count_next  = count_reg - cnt_t'(1);
                end
            end
            ST_SH_WR:
            begin
                idx_next = slot_inc(idx_reg);
            end
            ST_DONE:
            begin
                if (load_res)
                begin
                    valid_next   = 1'b1;
                    matched_next = found_reg;
                    if (found_reg)
                    begin
                        data_next = {exp_sat, drop_reg, best_d_reg[31:0], hit_reg.thread,
                                     hit_reg.proc, hit_reg.span, hit_reg.stamp, hit_reg.func};
                    end
                    else
                    begin
                        data_next = {exp_sat, drop_reg, 208'd0};
                    end
                end
            end
            default:
            begin
                found_next = found_reg;
            end
        endcase
    end

    // Slot of the best entry so far.
    always_comb
    begin
        hit_idx_next = hit_idx_reg;
        if (state_reg == ST_SC_CHK && verdict.hit && {1'b0, verdict.delta} < best_d_reg)
        begin
            hit_idx_next = idx_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            oldest_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
        end
    end

    // Working registers and the held item.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg  <= cmd;
            item_reg <= item;
        end
        exp_reg     <= exp_next;
        idx_reg     <= idx_next;
        left_reg    <= left_next;
        best_d_reg  <= best_d_next;
        found_reg   <= found_next;
        drop_reg    <= drop_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        matched_reg <= matched_next;
        data_reg    <= data_next;
    end

endmodule

FILE: rtl/core/esw_chk.sv
// ----------------------------------------------------------------------------
// esw_chk
// Port-level checks for the correlator, bound to the top level.
// ----------------------------------------------------------------------------
module esw_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [215:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // A stalled result item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result item changed");

    // One item at a time: no accept right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

    // Without a match the hit fields and gap are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[207:0] == 208'd0)
    else $error("hit fields set without a match");

    // A matched sample never reports a dropped entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tdata[208])
    else $error("dropped flag on a matched sample");

endmodule

bind event_sample_window_correlator_core esw_chk u_esw_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
